### rtl/dwpd_pkg.sv
`timescale 1ns / 1ps
package dwpd_pkg;

   localparam int DEFAULT_WINDOW = 16;

   localparam int SAMPLE_W    = 16;
   localparam int STEP_W      = 15;
   localparam int THRESH_W    = 15;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int HOLD_W      = 7;
   localparam int DIR_W       = 2;
   localparam int KIND_W      = 2;
   localparam int RSP_DATA_W  = 8;

   localparam logic [HOLD_W-1:0] HOLDOFF_MAX = 7'd127;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_STEP       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_BASELINE  = 2'd2;

   // Directions are kept as 2-bit two's complement values.
   localparam logic [DIR_W-1:0] DIR_NONE    = 2'b00;
   localparam logic [DIR_W-1:0] DIR_FALLING = 2'b01;
   localparam logic [DIR_W-1:0] DIR_RISING  = 2'b11;

   localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POSITIVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEGATIVE = 2'd2;

endpackage

### rtl/direction_window_peak_detector_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  req_tdata[15:0] sample_value (signed)
// rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata[1:0] peak_kind, [7:2] zero
// csr_      in         csr_wen                csr_index, csr_wdata[15:0]
//
// One sample item is taken per cycle while req_tready is high; its result item is
// registered in the output stage. The window update is a single add on a running
// sum, so the direction cell chain shifts in the same cycle a directed sample is accepted.
// Reset is synchronous and active high; it clears registers, window and holdoff.
// A two-entry output stage lets input keep flowing for one stalled result;
// req_tready drops only when both output entries are occupied.
module direction_window_peak_detector_unit
   import dwpd_pkg::*;
#(
   parameter int WINDOW = DEFAULT_WINDOW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,   // [15:0] sample_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [1:0] peak_kind, [7:2] zero fill
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // The running sum spans -WINDOW..WINDOW and needs a sign bit.
   localparam int SUM_W = $clog2(WINDOW + 1) + 1;
   // Wide enough for sample +/- a 15-bit magnitude without wrap.
   localparam int WIDE_W = SAMPLE_W + 2;

   // Configuration registers.
   logic [STEP_W-1:0]          min_step_ff;
   logic [THRESH_W-1:0]        peak_threshold_ff;
   logic signed [SAMPLE_W-1:0] peak_baseline_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_step_ff       <= '0;
         peak_threshold_ff <= '0;
         peak_baseline_ff  <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_MIN_STEP:       min_step_ff       <= csr_wdata[STEP_W-1:0];
            CSR_PEAK_THRESHOLD: peak_threshold_ff <= csr_wdata[THRESH_W-1:0];
            CSR_PEAK_BASELINE:  peak_baseline_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Detector state.
   logic signed [SAMPLE_W-1:0] reference_ff, reference_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [HOLD_W-1:0]          holdoff_ff, holdoff_in;

   logic                       accept;
   logic                       out_ready;
   logic [DIR_W-1:0]           dir_new;
   logic [DIR_W-1:0]           dir_oldest;
   logic                       shift_en;
   logic [KIND_W-1:0]          kind;

   logic signed [WIDE_W-1:0]   sample_w, ref_w, step_w, thr_w, base_w;
   logic [HOLD_W-1:0]          holdoff_inc;
   logic signed [SUM_W-1:0]    dir_new_w, dir_old_w;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = out_ready;

   // The direction window is a chain of cells; the oldest direction falls
   // out of the last cell whenever a new direction is shifted in.
   logic [DIR_W-1:0] chain [WINDOW+1];
   assign chain[0]   = dir_new;
   assign dir_oldest = chain[WINDOW];

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      dwpd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .dir_in   (chain[i]),
         .dir_out  (chain[i+1])
      );
   end

   always_comb begin
      sample_w = WIDE_W'(signed'(req_tdata));
      ref_w    = WIDE_W'(reference_ff);
      step_w   = WIDE_W'({1'b0, min_step_ff});
      thr_w    = WIDE_W'({1'b0, peak_threshold_ff});
      base_w   = WIDE_W'(peak_baseline_ff);

      holdoff_inc = (holdoff_ff < HOLDOFF_MAX) ? holdoff_ff + 1'b1 : holdoff_ff;

      // A sample that rose beyond the dead band gives -1, one that fell gives +1.
      if (ref_w < sample_w - step_w) begin
         dir_new = DIR_RISING;
      end else if (ref_w > sample_w + step_w) begin
         dir_new = DIR_FALLING;
      end else begin
         dir_new = DIR_NONE;
      end

      shift_en  = accept && (dir_new != DIR_NONE);
      dir_new_w = SUM_W'(signed'(dir_new));
      dir_old_w = SUM_W'(signed'(dir_oldest));

      reference_in = reference_ff;
      sum_in       = sum_ff;
      holdoff_in   = holdoff_ff;
      kind         = KIND_NONE;

      if (accept) begin
         holdoff_in = holdoff_inc;
         if (shift_en) begin
            reference_in = req_tdata;
            sum_in       = sum_ff - dir_old_w + dir_new_w;
            // A balanced window after a long enough quiet time marks a peak;
            // the positive side wins when both thresholds are met.
            if (sum_in == '0 && holdoff_inc > HOLD_W'(WINDOW)) begin
               if (sample_w >= base_w + thr_w) begin
                  kind       = KIND_POSITIVE;
                  holdoff_in = '0;
               end else if (sample_w <= base_w - thr_w) begin
                  kind       = KIND_NEGATIVE;
                  holdoff_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff <= '0;
         sum_ff       <= '0;
         holdoff_ff   <= '0;
      end else begin
         reference_ff <= reference_in;
         sum_ff       <= sum_in;
         holdoff_ff   <= holdoff_in;
      end
   end

   // Output stage: every accepted sample yields exactly one result item.
   dwpd_skid #(
      .WIDTH (RSP_DATA_W)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (out_ready),
      .in_data   (RSP_DATA_W'(kind)),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // The running sum always stays within the window's reach.
   a_sum_range : assert property (@(posedge clock) disable iff (reset)
      (sum_ff <= SUM_W'(WINDOW)) && (sum_ff >= -SUM_W'(WINDOW)))
      else $error("direction sum out of window range");

   // A reported peak always restarts the holdoff.
   a_peak_clears_holdoff : assert property (@(posedge clock) disable iff (reset)
      accept && (kind != KIND_NONE) |=> holdoff_ff == '0)
      else $error("holdoff not cleared after peak");

   // An ignored sample leaves the reference and the sum unchanged.
   a_ignored_holds : assert property (@(posedge clock) disable iff (reset)
      accept && (dir_new == DIR_NONE) |=> $stable(reference_ff) && $stable(sum_ff))
      else $error("ignored sample changed detector state");

   // Only defined peak codes leave the block.
   a_kind_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[KIND_W-1:0] == KIND_NONE
                      || rsp_tdata[KIND_W-1:0] == KIND_POSITIVE
                      || rsp_tdata[KIND_W-1:0] == KIND_NEGATIVE))
      else $error("undefined peak code on output");

endmodule

### rtl/dwpd_cell.sv
`timescale 1ns / 1ps
module dwpd_cell
   import dwpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [DIR_W-1:0] dir_in,
   output logic [DIR_W-1:0] dir_out
);

   logic [DIR_W-1:0] dir_ff;
   logic [DIR_W-1:0] dir_next_in;

   // The next value of this cell is the neighbor's direction on a shift.
   always_comb begin
      dir_next_in = shift_en ? dir_in : dir_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_NONE;
      end else begin
         dir_ff <= dir_next_in;
      end
   end

   assign dir_out = dir_ff;

endmodule

### rtl/dwpd_skid.sv
`timescale 1ns / 1ps
module dwpd_skid
   import dwpd_pkg::*;
#(
   parameter int WIDTH = RSP_DATA_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             main_valid_ff, main_valid_in;
   logic [WIDTH-1:0] main_data_ff, main_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
